/* rtl/lpbd_pkg.sv */
package lpbd_pkg;

	localparam int LENGTH_WIDTH        = 16;
	localparam int MAX_HEADER_BITS_DEF = 32;

	localparam int HDR_CFG_W  = 6;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_ADDR_W-1:0] REG_HEADER_BITS = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_MTU_BITS    = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_MSB_FIRST   = 2'd2;

	localparam logic [HDR_CFG_W-1:0]    HEADER_BITS_RST = 6'd8;
	localparam logic [LENGTH_WIDTH-1:0] MTU_BITS_RST    = 16'd2048;
	localparam logic                    MSB_FIRST_RST   = 1'b1;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;

	typedef struct packed {
		logic [HDR_CFG_W-1:0]    header_bits;
		logic [LENGTH_WIDTH-1:0] mtu_bits;
		logic                    msb_first;
	} cfg_t;

	typedef struct packed {
		logic                    out_bit;
		logic                    first_of_packet;
		logic [LENGTH_WIDTH-1:0] packet_length;
		logic                    last_of_packet;
	} res_t;

	typedef enum logic [2:0] {
		PH_SEARCH  = 3'b001,
		PH_HEADER  = 3'b010,
		PH_PAYLOAD = 3'b100
	} phase_t;

endpackage

/* rtl/lpbd_cfg.sv */
module lpbd_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lpbd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [lpbd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output lpbd_pkg::cfg_t                      cfg
);

	lpbd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_bits <= lpbd_pkg::HEADER_BITS_RST;
			cfg_q.mtu_bits    <= lpbd_pkg::MTU_BITS_RST;
			cfg_q.msb_first   <= lpbd_pkg::MSB_FIRST_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				lpbd_pkg::REG_HEADER_BITS: begin
					cfg_q.header_bits <= cfg_wdata[lpbd_pkg::HDR_CFG_W-1:0];
				end
				lpbd_pkg::REG_MTU_BITS: begin
					cfg_q.mtu_bits <= cfg_wdata[lpbd_pkg::LENGTH_WIDTH-1:0];
				end
				lpbd_pkg::REG_MSB_FIRST: begin
					cfg_q.msb_first <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/lpbd_core.sv */
module lpbd_core #(
	parameter int MAX_HEADER_BITS = lpbd_pkg::MAX_HEADER_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lpbd_pkg::cfg_t cfg,
	input  logic           step,
	input  logic           in_bit,
	input  logic           in_mark,
	output logic           res_valid,
	output lpbd_pkg::res_t res
);

	localparam int HVW  = MAX_HEADER_BITS;
	localparam int CW   = $clog2(MAX_HEADER_BITS + 1);
	localparam int LW   = lpbd_pkg::LENGTH_WIDTH;
	localparam int LENW = HVW + 3;
	localparam int CMPW = (LENW > LW) ? LENW : LW;

	lpbd_pkg::phase_t phase_q, phase_d;
	logic [HVW-1:0]   hv_q, hv_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [LW-1:0]    left_q, left_d;
	logic [LW-1:0]    total_q, total_d;
	logic             first_q, first_d;

	logic [CW-1:0]    n_eff;
	logic [HVW-1:0]   base_hv, hv_take;
	logic [CW-1:0]    base_cnt, cnt_take;
	logic [LENW-1:0]  len;
	logic             hdr_done, len_ok, last_bit;

	always_comb begin
		if (cfg.header_bits == '0)
			n_eff = CW'(1);
		else if (cfg.header_bits > lpbd_pkg::HDR_CFG_W'(MAX_HEADER_BITS))
			n_eff = CW'(MAX_HEADER_BITS);
		else
			n_eff = CW'(cfg.header_bits);
	end

	// a new header starts from zero on a sync mark
	assign base_hv  = (phase_q == lpbd_pkg::PH_HEADER) ? hv_q : '0;
	assign base_cnt = (phase_q == lpbd_pkg::PH_HEADER) ? cnt_q : '0;

	assign hv_take  = cfg.msb_first ? HVW'({base_hv, in_bit})
	                                : (base_hv | (HVW'(in_bit) << base_cnt));
	assign cnt_take = base_cnt + CW'(1);
	assign hdr_done = (cnt_take >= n_eff);
	assign len      = {hv_take, 3'b000};
	assign len_ok   = (len != '0) && (CMPW'(len) <= CMPW'(cfg.mtu_bits));
	assign last_bit = (left_q <= LW'(1));

	always_comb begin
		phase_d = phase_q;
		hv_d    = hv_q;
		cnt_d   = cnt_q;
		left_d  = left_q;
		total_d = total_q;
		first_d = first_q;

		res_valid           = 1'b0;
		res.out_bit         = in_bit;
		res.first_of_packet = first_q;
		res.packet_length   = first_q ? total_q : '0;
		res.last_of_packet  = last_bit;

		unique case (phase_q) inside
			lpbd_pkg::PH_PAYLOAD: begin
				res_valid = 1'b1;
				first_d   = 1'b0;
				if (last_bit) begin
					left_d  = '0;
					phase_d = lpbd_pkg::PH_SEARCH;
				end else begin
					left_d = left_q - LW'(1);
				end
			end
			lpbd_pkg::PH_HEADER, lpbd_pkg::PH_SEARCH: begin
				if (phase_q == lpbd_pkg::PH_HEADER || in_mark) begin
					hv_d  = hv_take;
					cnt_d = cnt_take;
					if (!hdr_done) begin
						phase_d = lpbd_pkg::PH_HEADER;
					end else if (!len_ok) begin
						phase_d = lpbd_pkg::PH_SEARCH;
					end else begin
						left_d  = LW'(len);
						total_d = LW'(len);
						first_d = 1'b1;
						phase_d = lpbd_pkg::PH_PAYLOAD;
					end
				end
			end
			default: begin
				phase_d = lpbd_pkg::PH_SEARCH;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lpbd_pkg::PH_SEARCH;
			hv_q    <= '0;
			cnt_q   <= '0;
			left_q  <= '0;
			total_q <= '0;
			first_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			hv_q    <= hv_d;
			cnt_q   <= cnt_d;
			left_q  <= left_d;
			total_q <= total_d;
			first_q <= first_d;
		end
	end

endmodule

/* rtl/length_prefixed_bit_deframer_unit.sv */
// channel  dir  tdata                                    tuser            tlast
// s_axis   in   [0] data_bit                             [0] sync_mark    -
// m_axis   out  [0] out_bit, [16:1] packet_length        [0] first_of_packet  last_of_packet
// cfg      in   cfg_addr 0 header_bits, 1 mtu_bits, 2 msb_first; write on cfg_we
//
// One bit per clock sustained while m_axis accepts results. A bit is held in the
// input register, then a single combinational step updates the deframer state
// and loads the output register.
// Reset clears the state to sync search and the registers to their defaults.
// A stall on m_axis holds the input register; s_axis_tready drops only when
// both the input and output registers are full.
module length_prefixed_bit_deframer_unit #(
	parameter int MAX_HEADER_BITS = lpbd_pkg::MAX_HEADER_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [lpbd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [0] data_bit
	input  logic                                s_axis_tuser,  // [0] sync_mark

	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [lpbd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [0] out_bit, [16:1] packet_length
	output logic                                m_axis_tuser,  // [0] first_of_packet
	output logic                                m_axis_tlast,

	input  logic                                cfg_we,
	input  logic [lpbd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [lpbd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int PADW = lpbd_pkg::OUT_TDATA_W - lpbd_pkg::LENGTH_WIDTH - 1;

	lpbd_pkg::cfg_t cfg;
	lpbd_pkg::res_t res, res_q;
	logic           res_valid;
	logic           valid_s1, bit_s1, mark_s1;
	logic           out_valid_q;
	logic           out_free, step;

	lpbd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign out_free      = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			bit_s1  <= s_axis_tdata[0];
			mark_s1 <= s_axis_tuser;
		end
	end

	lpbd_core #(
		.MAX_HEADER_BITS (MAX_HEADER_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (step),
		.in_bit    (bit_s1),
		.in_mark   (mark_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{PADW{1'b0}}, res_q.packet_length, res_q.out_bit};
	assign m_axis_tuser  = res_q.first_of_packet;
	assign m_axis_tlast  = res_q.last_of_packet;

endmodule

/* sim/length_prefixed_bit_deframer_unit_chk.sv */
`timescale 1ns / 1ps

module length_prefixed_bit_deframer_unit_chk
	import lpbd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	input  logic                    s_axis_tready,
	input  logic [IN_TDATA_W-1:0]   s_axis_tdata,   // [0] data_bit
	input  logic                    s_axis_tuser,   // [0] sync_mark
	input  logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	input  logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // [0] out_bit, [16:1] packet_length
	input  logic                    m_axis_tuser,   // [0] first_of_packet
	input  logic                    m_axis_tlast,
	input  logic                    cfg_we,
	input  logic [CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [CFG_DATA_W-1:0]   cfg_wdata,
	output int                      mismatches,
	output int                      owed,
	output int                      bits_checked,
	output int                      packets_checked
);

	logic [HDR_CFG_W-1:0]    hdr_cfg;
	logic [LENGTH_WIDTH-1:0] mtu_cfg;
	logic                    msb_cfg;

	phase_t                  ph;
	logic [31:0]             hdr_val;
	logic [5:0]              hdr_cnt;
	logic [LENGTH_WIDTH-1:0] left_bits;
	logic [LENGTH_WIDTH-1:0] total_bits;
	logic                    first_due;

	res_t                    owed_q[$];

	function void take_header_bit(input logic b);
		logic [5:0]  width;
		logic [63:0] len;
		width = (hdr_cfg == 6'd0) ? 6'd1 : ((hdr_cfg > 6'd32) ? 6'd32 : hdr_cfg);
		if (msb_cfg)
			hdr_val = {hdr_val[30:0], b};
		else if (hdr_cnt < 6'd32)
			hdr_val = hdr_val | (32'(b) << hdr_cnt);
		hdr_cnt = hdr_cnt + 6'd1;
		if (hdr_cnt < width) begin
			ph = PH_HEADER;
			return;
		end
		len = {32'd0, hdr_val} * 64'd8;
		if (len == 64'd0 || len > {48'd0, mtu_cfg} || len > 64'hFFFF) begin
			ph = PH_SEARCH;
		end else begin
			left_bits  = len[LENGTH_WIDTH-1:0];
			total_bits = len[LENGTH_WIDTH-1:0];
			first_due  = 1'b1;
			ph         = PH_PAYLOAD;
		end
	endfunction

	function void deframe_bit(input logic b, input logic m);
		res_t r;
		if (ph == PH_PAYLOAD) begin
			r.out_bit         = b;
			r.first_of_packet = first_due;
			r.packet_length   = first_due ? total_bits : '0;
			r.last_of_packet  = (left_bits <= 1);
			first_due = 1'b0;
			if (left_bits <= 1) begin
				left_bits = '0;
				ph = PH_SEARCH;
			end else begin
				left_bits = left_bits - 1'b1;
			end
			owed_q.push_back(r);
		end else if (ph == PH_HEADER) begin
			take_header_bit(b);
		end else if (m) begin
			hdr_val = '0;
			hdr_cnt = '0;
			take_header_bit(b);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t exp_r;
		logic [LENGTH_WIDTH-1:0] got_len;
		if (!arst_n) begin
			hdr_cfg    = HEADER_BITS_RST;
			mtu_cfg    = MTU_BITS_RST;
			msb_cfg    = MSB_FIRST_RST;
			ph         = PH_SEARCH;
			hdr_val    = '0;
			hdr_cnt    = '0;
			left_bits  = '0;
			total_bits = '0;
			first_due  = 1'b0;
			owed_q.delete();
			mismatches      = 0;
			owed            = 0;
			bits_checked    = 0;
			packets_checked = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_HEADER_BITS: hdr_cfg = cfg_wdata[HDR_CFG_W-1:0];
					REG_MTU_BITS:    mtu_cfg = cfg_wdata[LENGTH_WIDTH-1:0];
					REG_MSB_FIRST:   msb_cfg = cfg_wdata[0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				deframe_bit(s_axis_tdata[0], s_axis_tuser);
			if (m_axis_tvalid && m_axis_tready) begin
				got_len = m_axis_tdata[LENGTH_WIDTH:1];
				if (owed_q.size() == 0) begin
					$error("unexpected result transaction: bit %0b len %0d first %0b last %0b",
						m_axis_tdata[0], got_len, m_axis_tuser, m_axis_tlast);
					mismatches++;
				end else begin
					exp_r = owed_q.pop_front();
					bits_checked++;
					if (exp_r.first_of_packet)
						packets_checked++;
					if (m_axis_tdata[0] !== exp_r.out_bit) begin
						$error("out_bit: expected %0b, got %0b", exp_r.out_bit, m_axis_tdata[0]);
						mismatches++;
					end
					if (m_axis_tuser !== exp_r.first_of_packet) begin
						$error("first_of_packet: expected %0b, got %0b",
							exp_r.first_of_packet, m_axis_tuser);
						mismatches++;
					end
					if (got_len !== exp_r.packet_length) begin
						$error("packet_length: expected %0d, got %0d", exp_r.packet_length, got_len);
						mismatches++;
					end
					if (m_axis_tlast !== exp_r.last_of_packet) begin
						$error("last_of_packet: expected %0b, got %0b",
							exp_r.last_of_packet, m_axis_tlast);
						mismatches++;
					end
				end
			end
			owed = owed_q.size();
		end
	end

endmodule

/* sim/length_prefixed_bit_deframer_unit_tb.sv */
`timescale 1ns / 1ps

module length_prefixed_bit_deframer_unit_tb;
	import lpbd_pkg::*;

	localparam int RUN_LIMIT = 400000;

	// directed bits, index 0 first: noise, zero-length header, two 8-bit packets
	localparam logic [0:21] DIR_BIT  = 22'b0101_1010_1011_1110_1011_01;
	localparam logic [0:21] DIR_MARK = 22'b0011_1011_0010_0101_1001_01;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;   // [0] data_bit
	logic                    s_axis_tuser = 1'b0; // [0] sync_mark
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;        // [0] out_bit, [16:1] packet_length
	logic                    m_axis_tuser;        // [0] first_of_packet
	logic                    m_axis_tlast;
	logic                    cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0]   cfg_addr = '0;
	logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

	int                      mismatches;
	int                      owed;
	int                      bits_checked;
	int                      packets_checked;

	bit                      quiet = 1'b0;
	int                      cycles = 0;
	int                      items_sent = 0;
	int                      settings_run = 0;
	int                      hb_eff = 8;
	logic [15:0]             mtu_now = MTU_BITS_RST;
	logic                    msb_now = MSB_FIRST_RST;

	length_prefixed_bit_deframer_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	length_prefixed_bit_deframer_unit_chk u_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.m_axis_tlast    (m_axis_tlast),
		.cfg_we          (cfg_we),
		.cfg_addr        (cfg_addr),
		.cfg_wdata       (cfg_wdata),
		.mismatches      (mismatches),
		.owed            (owed),
		.bits_checked    (bits_checked),
		.packets_checked (packets_checked)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RUN_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(negedge clk)
		m_axis_tready <= quiet || ($urandom_range(0, 99) >= 32);

	task automatic send_item(input logic b, input logic m);
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < 32) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, b};
		s_axis_tuser  <= m;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic write_regs(input logic [5:0] hb, input logic [15:0] mtu, input logic msb);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_HEADER_BITS;
		cfg_wdata <= {10'($urandom), hb};
		@(negedge clk);
		cfg_addr  <= REG_MTU_BITS;
		cfg_wdata <= mtu;
		@(negedge clk);
		cfg_addr  <= REG_MSB_FIRST;
		cfg_wdata <= {15'($urandom), msb};
		@(negedge clk);
		cfg_we    <= 1'b0;
		hb_eff  = (hb == 0) ? 1 : ((hb > 32) ? 32 : int'(hb));
		mtu_now = mtu;
		msb_now = msb;
	endtask

	// waits out every owed result, then the input-to-output latency
	task automatic drain();
		int spins;
		spins = 0;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (owed != 0 && spins < 20000) begin
			@(negedge clk);
			spins++;
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic send_frame();
		int          noise;
		int          r;
		int          maxk;
		int          cap;
		logic [31:0] fitmax;
		logic [31:0] hv;
		logic [63:0] len;
		noise = $urandom_range(0, 3);
		repeat (noise) send_item(1'($urandom_range(0, 1)), 1'b0);
		maxk   = int'(mtu_now) / 8;
		fitmax = (hb_eff == 32) ? 32'hFFFF_FFFF : (32'd1 << hb_eff) - 32'd1;
		cap    = (maxk > 40) ? 40 : maxk;
		if (cap > fitmax)
			cap = int'(fitmax);
		r = $urandom_range(0, 99);
		if (r < 12)
			hv = '0;
		else if (r < 26)
			hv = $urandom & fitmax;
		else if (r < 30)
			hv = (maxk + 1 > fitmax) ? fitmax : 32'(maxk + 1);
		else if (r < 34)
			hv = 32'(cap);
		else
			hv = (cap == 0) ? '0 : 32'($urandom_range(1, (cap < 6) ? cap : 6));
		len = {32'd0, hv} * 64'd8;
		// keep accepted payloads short
		if (len != 0 && len <= {48'd0, mtu_now} && len <= 64'hFFFF && hv > 40) begin
			hv  = hv % 40 + 1;
			len = {32'd0, hv} * 64'd8;
		end
		for (int i = 0; i < hb_eff; i++)
			send_item(msb_now ? hv[hb_eff-1-i] : hv[i],
				(i == 0) ? 1'b1 : 1'($urandom_range(0, 3) == 0));
		if (len != 0 && len <= {48'd0, mtu_now} && len <= 64'hFFFF)
			repeat (int'(len)) send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 99) < 30));
	endtask

	task automatic run_phase(input logic [5:0] hb, input logic [15:0] mtu, input logic msb,
			input bit calm, input int budget);
		int start;
		write_regs(hb, mtu, msb);
		quiet = calm;
		start = items_sent;
		while (items_sent - start < budget)
			send_frame();
		drain();
		settings_run++;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_regs(6'd0, 16'd16, 1'b0);
		for (int i = 0; i < 22; i++)
			send_item(DIR_BIT[i], DIR_MARK[i]);
		drain();
		settings_run++;

		run_phase(6'd8,  16'd2048,  1'b1, 1'b0, 120);
		run_phase(6'd1,  16'd65535, 1'b0, 1'b0, 120);
		run_phase(6'd5,  16'd203,   1'b1, 1'b1, 120);
		run_phase(6'd32, 16'd65535, 1'b1, 1'b0, 120);
		run_phase(6'd45, 16'd320,   1'b0, 1'b0, 120);
		run_phase(6'd16, 16'd0,     1'b1, 1'b0, 64);
		run_phase(6'd12, 16'd64,    1'b0, 1'b0, 120);
		run_phase(6'd63, 16'd65535, 1'b0, 1'b0, 120);
		run_phase(6'd2,  16'd8,     1'b1, 1'b0, 120);

		repeat (10) @(negedge clk);
		if (owed != 0)
			$error("%0d expected result transactions never arrived", owed);
		$display("Sent %0d input bits across %0d register settings", items_sent, settings_run);
		$display("Compared %0d payload bits in %0d packets", bits_checked, packets_checked);
		if (mismatches == 0 && owed == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* length_prefixed_bit_deframer_unit.f */
rtl/lpbd_pkg.sv
rtl/lpbd_cfg.sv
rtl/lpbd_core.sv
rtl/length_prefixed_bit_deframer_unit.sv
sim/length_prefixed_bit_deframer_unit_chk.sv
sim/length_prefixed_bit_deframer_unit_tb.sv
